### rtl/sbda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared types and constants for the signed binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sbda_pkg;

    localparam int          VALUE_WIDTH  = 16;
    localparam int          DIGIT_BITS   = 4;
    // decimal digits needed for the largest magnitude, 2^(VALUE_WIDTH-1)
    localparam int          NUM_DIGITS   = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int          BCD_W        = DIGIT_BITS * NUM_DIGITS;
    localparam logic [3:0]  BCD_ADJ_MIN  = 4'd5;
    localparam logic [3:0]  BCD_ADJ_ADD  = 4'd3;
    localparam logic [7:0]  ASCII_ZERO   = 8'h30;
    localparam logic [7:0]  ASCII_MINUS  = 8'h2D;

    // one input sample
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic [7:0]                    delimiter;
    } t_item;

    // one emitted byte
    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_result;

endpackage

### rtl/sbda_dabble_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbda_dabble_step
// One shift-add-3 step: adjusts every BCD digit that is 5 or more by 3, then
// shifts the BCD and binary registers left by one as a single word.
// ----------------------------------------------------------------------------
module sbda_dabble_step
    import sbda_pkg::*;
(
    input  logic [BCD_W-1:0]       i_bcd,
    input  logic [VALUE_WIDTH-1:0] i_bin,
    output logic [BCD_W-1:0]       o_bcd,
    output logic [VALUE_WIDTH-1:0] o_bin
);

    logic [BCD_W-1:0] w_adj;

    // add-3 correction, each digit on its own
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (i_bcd[d*DIGIT_BITS +: DIGIT_BITS] >= BCD_ADJ_MIN) begin
                w_adj[d*DIGIT_BITS +: DIGIT_BITS] =
                    i_bcd[d*DIGIT_BITS +: DIGIT_BITS] + BCD_ADJ_ADD;
            end else begin
                w_adj[d*DIGIT_BITS +: DIGIT_BITS] = i_bcd[d*DIGIT_BITS +: DIGIT_BITS];
            end
        end
    end

    // shift the binary MSB into the BCD word
    assign o_bcd = {w_adj[BCD_W-2:0], i_bin[VALUE_WIDTH-1]};
    assign o_bin = {i_bin[VALUE_WIDTH-2:0], 1'b0};

endmodule

### rtl/signed_binary_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Converts a signed value to decimal ASCII, most significant digit first,
// without leading zeros, with a leading '-' for negatives, then the delimiter.
//
// Channel   Direction  Handshake            Payload
// input     in         start / busy         i_item.value, i_item.delimiter
// result    out        o_valid (strobe)     o_result.character, o_result.last
//
// Sequence: a transfer at an idle edge starts the item; busy then stays high
// through the shift-add-3 steps, a sign state, a scan that drops leading
// zeros, the digit output and a delimiter state, and a new transfer is taken
// only back in idle; the length of an item does not depend on the value.
// Reset clears the sequencer and the strobe. The receiver cannot stall; each
// result is valid on o_result only in the single cycle that o_valid marks.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii
    import sbda_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_valid,
    output t_result o_result
);

    localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_SIGN  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DIGIT = 3'd4;
    localparam logic [2:0] S_DELIM = 3'd5;

    logic [2:0]             r_state,  n_state;
    logic [BIT_CNT_W-1:0]   r_bits,   n_bits;
    logic [DIG_CNT_W-1:0]   r_digs,   n_digs;
    logic [VALUE_WIDTH-1:0] r_bin,    n_bin;
    logic [BCD_W-1:0]       r_bcd,    n_bcd;
    logic                   r_neg,    n_neg;
    logic [7:0]             r_delim,  n_delim;
    logic                   r_valid,  n_valid;
    t_result                r_result, n_result;

    logic [BCD_W-1:0]       w_step_bcd;
    logic [VALUE_WIDTH-1:0] w_step_bin;
    logic [DIGIT_BITS-1:0]  w_top;
    logic [BCD_W-1:0]       w_bcd_shl;

    sbda_dabble_step u_step (
        .i_bcd (r_bcd),
        .i_bin (r_bin),
        .o_bcd (w_step_bcd),
        .o_bin (w_step_bin)
    );

    // most significant remaining digit, and the word with it shifted out
    assign w_top     = r_bcd[BCD_W-1 -: DIGIT_BITS];
    assign w_bcd_shl = {r_bcd[BCD_W-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_bits   = r_bits;
        n_digs   = r_digs;
        n_bin    = r_bin;
        n_bcd    = r_bcd;
        n_neg    = r_neg;
        n_delim  = r_delim;
        n_valid  = 1'b0;
        n_result = r_result;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    // magnitude; the most negative value lands on the sign bit
                    n_neg   = i_item.value[VALUE_WIDTH-1];
                    n_bin   = i_item.value[VALUE_WIDTH-1] ? (~i_item.value + 1'b1)
                                                          : i_item.value;
                    n_bcd   = '0;
                    n_delim = i_item.delimiter;
                    n_bits  = BIT_CNT_W'(VALUE_WIDTH);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd  = w_step_bcd;
                n_bin  = w_step_bin;
                n_bits = r_bits - 1'b1;
                if (r_bits == BIT_CNT_W'(1)) begin
                    n_digs  = DIG_CNT_W'(NUM_DIGITS);
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                if (r_neg) begin
                    n_valid            = 1'b1;
                    n_result.character = ASCII_MINUS;
                    n_result.last      = 1'b0;
                end
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // drop leading zeros, keep at least one digit
                if (w_top == '0 && r_digs != DIG_CNT_W'(1)) begin
                    n_bcd  = w_bcd_shl;
                    n_digs = r_digs - 1'b1;
                end else begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                n_valid            = 1'b1;
                n_result.character = ASCII_ZERO | {4'b0000, w_top};
                n_result.last      = 1'b0;
                n_bcd              = w_bcd_shl;
                n_digs             = r_digs - 1'b1;
                if (r_digs == DIG_CNT_W'(1)) begin
                    n_state = S_DELIM;
                end
            end
            S_DELIM: begin
                n_valid            = 1'b1;
                n_result.character = r_delim;
                n_result.last      = 1'b1;
                n_state            = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_bits   <= n_bits;
        r_digs   <= n_digs;
        r_bin    <= n_bin;
        r_bcd    <= n_bcd;
        r_neg    <= n_neg;
        r_delim  <= n_delim;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
